### sv/usc_pkg.sv
// usc_pkg: shared constants, types and helpers of the UV sphere cell vertex block.
// Holds the quarter-wave sine table, built at elaboration with exact integer math.
// No dependencies.
package usc_pkg;

  localparam int USC_MAX_SUBDIV = 64;
  localparam int SUBDIV_W       = 7;
  localparam int RADIUS_W       = 16;
  localparam int IDX_W          = 6;
  localparam int POS_W          = 17;
  localparam int TEX_W          = 17;
  localparam int NORM_W         = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [SUBDIV_W-1:0] SUBDIV_RESET = 7'd16;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;

  // quarter-wave table, entries 0..1023; entry 1024 (full scale) is implied
  localparam int QSIN_DEPTH = 1024;
  localparam int QSIN_W     = 15;
  localparam int QA_W       = $clog2(QSIN_DEPTH);
  localparam logic [QSIN_W-1:0] QSIN_ONE = 15'd16384;
  localparam int TRIG_FRAC  = 14;

  // reciprocal of the subdivision: ceil(2^RECIP_SHIFT / N)
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int DIV_CNT_W   = $clog2(RECIP_SHIFT);
  localparam int TEX_FRAC    = 16;
  localparam int Q_SHIFT     = RECIP_SHIFT - TEX_FRAC;

  localparam int VTX_PER_CELL = 6;
  localparam int VCNT_W       = $clog2(VTX_PER_CELL);
  localparam logic [VCNT_W-1:0] VTX_LAST = VCNT_W'(VTX_PER_CELL - 1);

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  // one table step of pi/2048 in Q60: whole part and remainder
  localparam logic [63:0] PI_STEP_Q60 = PI_Q60 / 64'd2048;
  localparam logic [63:0] PI_STEP_REM = PI_Q60 % 64'd2048;

  // Taylor denominators (2n)(2n+1) for n = 1..14
  localparam logic [63:0] TAYLOR_DEN [14] = '{
    64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUBDIVISION = 2'd0,
    CFG_RADIUS      = 2'd1
  } cfg_reg_t;

  typedef logic [QSIN_W-1:0] qsin_tab_t [QSIN_DEPTH];

  typedef struct packed {
    logic [QA_W-1:0] addr;
    logic            one;   // full-scale value, not stored in the table
    logic            neg;
  } trig_addr_t;

  typedef struct packed {
    logic row_off;
    logic col_off;
    logic last;
  } vtx_sel_t;

  // Taylor series in Q60, rounded to Q14
  function automatic qsin_tab_t build_qsin();
    qsin_tab_t     tab;
    logic [63:0]   x;
    logic [63:0]   x2;
    logic [63:0]   term;
    logic [63:0]   sum;
    logic [127:0]  prod;
    for (int k = 0; k < QSIN_DEPTH; k++) begin
      x = PI_STEP_Q60 * 64'(k) + ((PI_STEP_REM * 64'(k)) >> 11);
      prod = 128'(x) * 128'(x);
      x2 = prod[123:60];
      term = x;
      sum = x;
      for (int n = 1; n <= 14; n++) begin
        prod = 128'(term) * 128'(x2);
        term = prod[123:60] / TAYLOR_DEN[n - 1];
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      sum = sum + (64'd1 << 45);
      tab[k] = QSIN_W'(sum >> 46);
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();

  // 12-bit phase to table address, full-scale flag and sign
  function automatic trig_addr_t trig_addr(input logic [11:0] phase);
    trig_addr_t t;
    logic [QA_W-1:0] r;
    r = phase[QA_W-1:0];
    t.addr = phase[10] ? QA_W'(~r + 1'b1) : r;
    t.one  = phase[10] && (r == '0);
    t.neg  = phase[11];
    return t;
  endfunction

  function automatic logic signed [NORM_W-1:0] trig_val(input logic [QSIN_W-1:0] mag,
                                                        input trig_addr_t t);
    logic signed [NORM_W-1:0] v;
    v = $signed({1'b0, (t.one ? QSIN_ONE : mag)});
    return t.neg ? -v : v;
  endfunction

  // vertex order a, b, c, c, b, d
  function automatic vtx_sel_t vtx_sel(input logic [VCNT_W-1:0] vcnt);
    vtx_sel_t s;
    case (vcnt)
      3'd0: s = '{row_off: 1'b0, col_off: 1'b0, last: 1'b0};
      3'd1: s = '{row_off: 1'b1, col_off: 1'b0, last: 1'b0};
      3'd2: s = '{row_off: 1'b0, col_off: 1'b1, last: 1'b0};
      3'd3: s = '{row_off: 1'b0, col_off: 1'b1, last: 1'b0};
      3'd4: s = '{row_off: 1'b1, col_off: 1'b0, last: 1'b0};
      3'd5: s = '{row_off: 1'b1, col_off: 1'b1, last: 1'b1};
      default: s = '{row_off: 1'b0, col_off: 1'b0, last: 1'b0};
    endcase
    return s;
  endfunction

endpackage

### sv/usc_cell_if.sv
// usc_cell_if: input channel carrying one grid cell per transfer.
// Depends on usc_pkg.
interface usc_cell_if
  import usc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] lat_index;
  logic [IDX_W-1:0] lon_index;

  modport source(output valid, lat_index, lon_index, input ready);
  modport sink(input valid, lat_index, lon_index, output ready);
endinterface

### sv/usc_vtx_if.sv
// usc_vtx_if: output channel carrying one vertex per transfer.
// Depends on usc_pkg.
interface usc_vtx_if
  import usc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [TEX_W-1:0]         tex_u;
  logic [TEX_W-1:0]         tex_v;
  logic signed [NORM_W-1:0] norm_x;
  logic signed [NORM_W-1:0] norm_y;
  logic signed [NORM_W-1:0] norm_z;
  logic                     last;

  modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                 norm_x, norm_y, norm_z, last, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v,
               norm_x, norm_y, norm_z, last, output ready);
endinterface

### sv/usc_cfg_if.sv
// usc_cfg_if: register write channel (index and data per transfer).
// Depends on usc_pkg.
interface usc_cfg_if
  import usc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### sv/usc_ram.sv
// usc_ram: generic RAM, one write port and two registered read ports.
// No dependencies.
module usc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### sv/uv_sphere_cell_vertices.sv
// uv_sphere_cell_vertices: top level, grid cell in, six sphere vertices out.
// Depends on usc_pkg, usc_cell_if, usc_vtx_if, usc_cfg_if and usc_ram.
//
//   channel   | dir | transfer moves
//   ----------+-----+---------------------------------------------------------
//   cfg       | in  | register write: index (0 subdivision, 1 radius), data
//   grid_cell | in  | one grid cell: lat_index, lon_index
//   vtx       | out | one vertex: pos, tex, normal, last on the sixth
//
// Cycles: one vertex leaves the issue stage per cycle unless vtx stalls, and the
//   next cell is taken in the cycle its sixth vertex issues. The first vertex
//   of a cell passes the cell register, then the reciprocal multiply at issue,
//   the table read, the normal multiply and the position multiply before it
//   is valid on vtx.
// Reset: the sine table RAMs are loaded in a pass over all 1024 entries;
//   grid_cell.ready stays low until it ends. Cfg writes are taken at any time.
// A subdivision write starts the reciprocal division; grid_cell.ready
//   is low while it runs.
// Stalls: a vertex held on vtx freezes the whole vertex pipeline; a new cell
//   is still taken if the cell register is free.
module uv_sphere_cell_vertices
  import usc_pkg::*;
#(
  parameter int MAX_SUBDIVISION = USC_MAX_SUBDIV
) (
  input logic        clk,
  input logic        rst,
  usc_cfg_if.sink    cfg,
  usc_cell_if.sink   grid_cell,
  usc_vtx_if.source  vtx
);

  // ---------------- configuration ----------------
  logic [SUBDIV_W-1:0]   subdiv;
  logic [RADIUS_W-1:0]   radius;
  logic [SUBDIV_W-1:0]   cfg_sub_raw;
  logic [SUBDIV_W-1:0]   cfg_sub_clamped;
  logic                  cfg_wr;
  logic                  sub_wr;

  assign cfg.ready   = 1'b1;
  assign cfg_wr      = cfg.valid && cfg.ready;
  assign cfg_sub_raw = cfg.data[SUBDIV_W-1:0];
  assign sub_wr      = cfg_wr && (cfg.index == CFG_SUBDIVISION);

  always_comb begin
    if (cfg_sub_raw == '0) begin
      cfg_sub_clamped = SUBDIV_W'(1);
    end else if (int'(cfg_sub_raw) > MAX_SUBDIVISION) begin
      cfg_sub_clamped = SUBDIV_W'(MAX_SUBDIVISION);
    end else begin
      cfg_sub_clamped = cfg_sub_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      subdiv <= SUBDIV_RESET;
      radius <= RADIUS_RESET;
    end else if (cfg_wr) begin
      case (cfg.index)
        CFG_SUBDIVISION: subdiv <= cfg_sub_clamped;
        CFG_RADIUS:      radius <= cfg.data[RADIUS_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- reciprocal: recip = ceil(2^30 / N) ----------------
  // Restoring division of 2^30-1 by N, one quotient bit per cycle, plus one.
  logic                   div_busy;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [SUBDIV_W-1:0]    div_rem;
  logic [RECIP_SHIFT-1:0] div_quot;
  logic [RECIP_W-1:0]     recip;
  logic [SUBDIV_W:0]      div_trial;
  logic                   div_ge;
  logic [SUBDIV_W-1:0]    div_rem_next;
  logic [RECIP_SHIFT-1:0] div_quot_next;

  assign div_trial     = {div_rem, 1'b1};
  assign div_ge        = div_trial >= {1'b0, subdiv};
  assign div_rem_next  = div_ge ? SUBDIV_W'(div_trial - {1'b0, subdiv})
                                : div_trial[SUBDIV_W-1:0];
  assign div_quot_next = {div_quot[RECIP_SHIFT-2:0], div_ge};

  always_ff @(posedge clk) begin
    if (rst || sub_wr) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
      div_rem  <= '0;
      div_quot <= '0;
    end else if (div_busy) begin
      div_rem  <= div_rem_next;
      div_quot <= div_quot_next;
      div_cnt  <= div_cnt + 1'b1;
      if (div_cnt == DIV_CNT_W'(RECIP_SHIFT - 1)) begin
        div_busy <= 1'b0;
        recip    <= RECIP_W'({1'b0, div_quot_next} + 1'b1);
      end
    end
  end

  // ---------------- table load after reset ----------------
  logic            fill_busy;
  logic [QA_W-1:0] fill_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_busy <= 1'b1;
      fill_addr <= '0;
    end else if (fill_busy) begin
      fill_addr <= fill_addr + 1'b1;
      if (fill_addr == QA_W'(QSIN_DEPTH - 1)) begin
        fill_busy <= 1'b0;
      end
    end
  end

  logic busy;
  assign busy = fill_busy || div_busy;

  // ---------------- cell register and vertex issue ----------------
  logic              adv;        // vertex pipeline moves
  logic              cell_valid;
  logic [IDX_W-1:0]  cell_lat;
  logic [IDX_W-1:0]  cell_lon;
  logic [VCNT_W-1:0] vcnt;
  logic              issue;
  logic              issue_last;
  logic              cell_acc;
  logic [IDX_W-1:0]  lat_cl;
  logic [IDX_W-1:0]  lon_cl;

  logic s1_valid, s2_valid, s3_valid, s4_valid;

  assign adv             = !s4_valid || vtx.ready;
  assign issue           = adv && cell_valid;
  assign issue_last      = issue && (vcnt == VTX_LAST);
  assign grid_cell.ready = !busy && (!cell_valid || issue_last);
  assign cell_acc        = grid_cell.valid && grid_cell.ready;

  // indices at or above N clamp to N-1
  assign lat_cl = ({1'b0, grid_cell.lat_index} >= subdiv) ? IDX_W'(subdiv - 1'b1)
                                                          : grid_cell.lat_index;
  assign lon_cl = ({1'b0, grid_cell.lon_index} >= subdiv) ? IDX_W'(subdiv - 1'b1)
                                                          : grid_cell.lon_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
      vcnt       <= '0;
    end else if (cell_acc) begin
      cell_valid <= 1'b1;
      vcnt       <= '0;
    end else if (issue_last) begin
      cell_valid <= 1'b0;
    end else if (issue) begin
      vcnt <= vcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_acc) begin
      cell_lat <= lat_cl;
      cell_lon <= lon_cl;
    end
  end

  // ---------------- stage 1: grid position times reciprocal ----------------
  // q = floor(x * 65536 / N) for the vertex row and column
  vtx_sel_t                  sel;
  logic [IDX_W:0]            row;
  logic [IDX_W:0]            col;
  logic [IDX_W+RECIP_W-1:0]  row_prod;
  logic [IDX_W+RECIP_W-1:0]  col_prod;
  logic [TEX_W-1:0]          s1_qrow;
  logic [TEX_W-1:0]          s1_qcol;
  logic                      s1_last;

  assign sel      = vtx_sel(vcnt);
  assign row      = {1'b0, cell_lat} + (IDX_W+1)'(sel.row_off);
  assign col      = {1'b0, cell_lon} + (IDX_W+1)'(sel.col_off);
  assign row_prod = (IDX_W+RECIP_W)'(row) * (IDX_W+RECIP_W)'(recip);
  assign col_prod = (IDX_W+RECIP_W)'(col) * (IDX_W+RECIP_W)'(recip);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_qrow <= row_prod[Q_SHIFT+TEX_W-1:Q_SHIFT];
      s1_qcol <= col_prod[Q_SHIFT+TEX_W-1:Q_SHIFT];
      s1_last <= sel.last;
    end
  end

  // ---------------- stage 2: phases and table reads ----------------
  // lat = q_row/32 - 1024, lon = q_col/16, both mod 4096
  logic [11:0]      p_lat;
  logic [11:0]      p_lon;
  trig_addr_t       sa_lat, ca_lat, sa_lon, ca_lon;
  trig_addr_t       s2_sa_lat, s2_ca_lat, s2_sa_lon, s2_ca_lon;
  logic [TEX_W-1:0] s2_tex_u;
  logic [TEX_W-1:0] s2_tex_v;
  logic             s2_last;
  logic [QSIN_W-1:0] lat_sin_mag, lat_cos_mag, lon_sin_mag, lon_cos_mag;

  assign p_lat  = s1_qrow[TEX_W-1:5] + 12'd3072;
  assign p_lon  = s1_qcol[15:4];
  assign sa_lat = trig_addr(p_lat);
  assign ca_lat = trig_addr(p_lat + 12'd1024);
  assign sa_lon = trig_addr(p_lon);
  assign ca_lon = trig_addr(p_lon + 12'd1024);

  usc_ram #(
    .WIDTH(QSIN_W),
    .DEPTH(QSIN_DEPTH)
  ) u_ram_lat (
    .clk    (clk),
    .we     (fill_busy),
    .waddr  (fill_addr),
    .wdata  (QSIN_TAB[fill_addr]),
    .re     (adv),
    .raddr_a(sa_lat.addr),
    .raddr_b(ca_lat.addr),
    .rdata_a(lat_sin_mag),
    .rdata_b(lat_cos_mag)
  );

  usc_ram #(
    .WIDTH(QSIN_W),
    .DEPTH(QSIN_DEPTH)
  ) u_ram_lon (
    .clk    (clk),
    .we     (fill_busy),
    .waddr  (fill_addr),
    .wdata  (QSIN_TAB[fill_addr]),
    .re     (adv),
    .raddr_a(sa_lon.addr),
    .raddr_b(ca_lon.addr),
    .rdata_a(lon_sin_mag),
    .rdata_b(lon_cos_mag)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sa_lat <= sa_lat;
      s2_ca_lat <= ca_lat;
      s2_sa_lon <= sa_lon;
      s2_ca_lon <= ca_lon;
      s2_tex_u  <= s1_qcol;
      s2_tex_v  <= TEX_W'(17'd65536 - s1_qrow);
      s2_last   <= s1_last;
    end
  end

  // ---------------- stage 3: normal ----------------
  logic signed [NORM_W-1:0]   sl, cl, slon, clon;
  logic signed [2*NORM_W-1:0] pnx, pnz;
  logic signed [NORM_W-1:0]   s3_nx, s3_ny, s3_nz;
  logic [TEX_W-1:0]           s3_tex_u;
  logic [TEX_W-1:0]           s3_tex_v;
  logic                       s3_last;

  assign sl   = trig_val(lat_sin_mag, s2_sa_lat);
  assign cl   = trig_val(lat_cos_mag, s2_ca_lat);
  assign slon = trig_val(lon_sin_mag, s2_sa_lon);
  assign clon = trig_val(lon_cos_mag, s2_ca_lon);
  assign pnx  = cl * clon;
  assign pnz  = cl * slon;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_nx    <= pnx[TRIG_FRAC+NORM_W-1:TRIG_FRAC];  // floor, arithmetic
      s3_ny    <= sl;
      s3_nz    <= pnz[TRIG_FRAC+NORM_W-1:TRIG_FRAC];
      s3_tex_u <= s2_tex_u;
      s3_tex_v <= s2_tex_v;
      s3_last  <= s2_last;
    end
  end

  // ---------------- stage 4: position, output register ----------------
  logic signed [RADIUS_W:0]         rad_s;
  logic signed [RADIUS_W+NORM_W:0]  ppx, ppy, ppz;

  assign rad_s = $signed({1'b0, radius});
  assign ppx   = rad_s * s3_nx;
  assign ppy   = rad_s * s3_ny;
  assign ppz   = rad_s * s3_nz;

  always_ff @(posedge clk) begin
    if (adv) begin
      vtx.pos_x  <= ppx[TRIG_FRAC+POS_W-1:TRIG_FRAC];
      vtx.pos_y  <= ppy[TRIG_FRAC+POS_W-1:TRIG_FRAC];
      vtx.pos_z  <= ppz[TRIG_FRAC+POS_W-1:TRIG_FRAC];
      vtx.norm_x <= s3_nx;
      vtx.norm_y <= s3_ny;
      vtx.norm_z <= s3_nz;
      vtx.tex_u  <= s3_tex_u;
      vtx.tex_v  <= s3_tex_v;
      vtx.last   <= s3_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cell_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  assign vtx.valid = s4_valid;

`ifndef ASSERT_OFF
  a_vcnt_range: assert property (@(posedge clk) disable iff (rst)
    cell_valid |-> vcnt <= VTX_LAST)
    else $error("vertex counter past the sixth vertex");

  a_fill_once: assert property (@(posedge clk) disable iff (rst)
    !fill_busy |=> !fill_busy)
    else $error("table load restarted without reset");

  a_recip_set: assert property (@(posedge clk) disable iff (rst)
    !div_busy |-> recip != '0)
    else $error("reciprocal is zero after division");

  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    vtx.valid |-> (vtx.tex_u <= TEX_W'(65536)) && (vtx.tex_v <= TEX_W'(65536)))
    else $error("texture coordinate beyond one");
`endif

endmodule
